// ===== hdl/hue_ramp_color_mapper_macros.svh =====
// Assertion helpers for the hue ramp color mapper.
`ifndef HUE_RAMP_COLOR_MAPPER_MACROS_SVH
`define HUE_RAMP_COLOR_MAPPER_MACROS_SVH

// Implication in the same cycle, ignored while in reset.
`define HRCM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent, ignored while in reset.
`define HRCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent, checked through reset as well.
`define HRCM_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/hrcm_pkg.sv =====
`default_nettype none

package hrcm_pkg;

  // Q format of factors and channel fractions.
  localparam int FRACTION_BITS = 12;
  localparam int FACTOR_W      = FRACTION_BITS + 1;  // 0..ONE inclusive
  localparam int CHAN_W        = FRACTION_BITS + 1;  // channel fraction 0..ONE
  localparam int HUE_W         = FRACTION_BITS + 4;  // signed, -2*ONE..4*ONE
  localparam int TURN_W        = FRACTION_BITS + 2;  // wrapped hue 0..TURN-1
  localparam int COLOR_W       = 8;

  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_RAMP_FIRST  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_RAMP_SECOND = 1'b1;

  // Operation codes carried in the action field.
  localparam logic ACT_SINGLE = 1'b0;
  localparam logic ACT_BLEND  = 1'b1;

  // Hue ramps; any other code falls back to RAMP_FALL_TWICE.
  typedef enum logic [CFG_DATA_W-1:0] {
    RAMP_FALL_TWICE = 3'd0,  // ONE - 2f
    RAMP_RETURN     = 3'd1,  // 2*(ONE - f)
    RAMP_RISE_TWICE = 3'd2,  // ONE + 2f
    RAMP_RISE       = 3'd3,  // ONE + f
    RAMP_FALL       = 3'd4   // ONE - f
  } ramp_mode_t;

  typedef struct packed {
    logic                action;
    logic [FACTOR_W-1:0] factor_first;
    logic [FACTOR_W-1:0] factor_second;
  } item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } color_t;

  // Exact channel fractions of one HSL conversion.
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } frac_t;

endpackage

`default_nettype wire

// ===== hdl/hue_ramp_color_mapper.sv =====
`default_nettype none

// Hue ramp color mapper: each input word carries one or two Q12 intensity
// factors (4096 = 1.0, larger values clamp to 1.0) and an action bit; each
// output word is one 8-bit RGB color. The factor picks a hue along the ramp
// selected by ramp_first / ramp_second, the hue is converted as HSL with full
// saturation and half lightness, and in blend operation the two colors mix
// 70/30 per channel before scaling by 255 with truncation. The block is a
// three-register pipeline (input word, channel fractions, output color): it
// takes one word every clock while item_stall is low and returns the colors
// in order. Backpressure on color_stall ripples back only as far as needed,
// so item_stall rises only while the output holds a word that is not taken
// and the stages behind it are full. Ramp registers are written through
// cfg_write / cfg_index / cfg_data and act on every word that leaves the
// input register after the write; write them only while no word is in flight.
module hue_ramp_color_mapper (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // input words
  input  wire logic                            item_valid,
  output      logic                            item_stall,
  input  wire hrcm_pkg::item_t                 item,
  // output words
  output      logic                            color_valid,
  input  wire logic                            color_stall,
  output hrcm_pkg::color_t                     color,
  // ramp registers
  input  wire logic                            cfg_write,
  input  wire logic [hrcm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [hrcm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hrcm_pkg::*;

  // ramp mode registers
  logic [CFG_DATA_W-1:0] ramp_first;
  logic [CFG_DATA_W-1:0] ramp_second;

  // stage 1: registered input word
  logic  s1_valid;
  item_t s1_item;

  // stage 2: channel fractions of both conversions
  logic  s2_valid;
  logic  s2_action;
  frac_t s2_first;
  frac_t s2_second;

  // combinational results
  frac_t  conv_first;
  frac_t  conv_second;
  color_t color_next;

  // per-stage advance: a stage loads when empty or when its word moves on
  logic ready3;
  logic ready2;
  logic ready1;

  assign ready3     = !color_valid || !color_stall;
  assign ready2     = !s2_valid || ready3;
  assign ready1     = !s1_valid || ready2;
  assign item_stall = !ready1;

  hrcm_hue_conv u_conv_first (
    .factor (s1_item.factor_first),
    .mode   (ramp_first),
    .frac   (conv_first)
  );

  hrcm_hue_conv u_conv_second (
    .factor (s1_item.factor_second),
    .mode   (ramp_second),
    .frac   (conv_second)
  );

  hrcm_scale u_scale (
    .action      (s2_action),
    .frac_first  (s2_first),
    .frac_second (s2_second),
    .color       (color_next)
  );

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      color_valid <= 1'b0;
      ramp_first  <= RAMP_FALL_TWICE;
      ramp_second <= RAMP_FALL_TWICE;
    end else begin
      if (ready1) begin
        s1_valid <= item_valid;
      end
      if (ready2) begin
        s2_valid <= s1_valid;
      end
      if (ready3) begin
        color_valid <= s2_valid;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_RAMP_FIRST:  ramp_first  <= cfg_data;
          REG_RAMP_SECOND: ramp_second <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (ready1 && item_valid) begin
      s1_item <= item;
    end
    if (ready2 && s1_valid) begin
      s2_action <= s1_item.action;
      s2_first  <= conv_first;
      s2_second <= conv_second;
    end
    if (ready3 && s2_valid) begin
      color <= color_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hrcm_hue_conv.sv =====
`default_nettype none

// Factor + ramp mode -> hue -> RGB fractions (S = 1, L = 0.5).
module hrcm_hue_conv (
  input  wire logic [hrcm_pkg::FACTOR_W-1:0]   factor,
  input  wire logic [hrcm_pkg::CFG_DATA_W-1:0] mode,
  output hrcm_pkg::frac_t                      frac
);
  import hrcm_pkg::*;

  localparam logic signed [HUE_W-1:0]  ONE_H     = HUE_W'(1 << FRACTION_BITS);
  localparam logic signed [HUE_W-1:0]  TWO_ONE_H = HUE_W'(2 << FRACTION_BITS);
  localparam logic signed [HUE_W-1:0]  TURN_H    = HUE_W'(3 << FRACTION_BITS);
  localparam logic [FACTOR_W-1:0]      ONE_F     = FACTOR_W'(1 << FRACTION_BITS);
  localparam logic [TURN_W-1:0]        HALF_ONE  = TURN_W'(1 << (FRACTION_BITS - 1));
  localparam logic [TURN_W-1:0]        HALF_TURN = TURN_W'(3 << (FRACTION_BITS - 1));
  localparam logic [TURN_W-1:0]        TWO_ONE_T = TURN_W'(2 << FRACTION_BITS);
  localparam logic [CHAN_W-1:0]        ONE_C     = CHAN_W'(1 << FRACTION_BITS);

  // Channel fraction at one hue position; hue is wrapped into one turn first.
  function automatic logic [CHAN_W-1:0] hue_channel(logic signed [HUE_W-1:0] h);
    logic signed [HUE_W-1:0] w;
    logic [TURN_W-1:0]       u;
    logic [CHAN_W-1:0]       c;
    w = h;
    if (h < 0) begin
      w = h + TURN_H;
    end else if (h >= TURN_H) begin
      w = h - TURN_H;
    end
    u = w[TURN_W-1:0];
    priority if (u < HALF_ONE) begin
      c = CHAN_W'({u, 1'b0});                    // rising edge
    end else if (u < HALF_TURN) begin
      c = ONE_C;                                 // plateau
    end else if (u < TWO_ONE_T) begin
      c = CHAN_W'({TWO_ONE_T - u, 1'b0});        // falling edge
    end else begin
      c = '0;
    end
    return c;
  endfunction

  logic [FACTOR_W-1:0]     f_sat;
  logic signed [HUE_W-1:0] f_s;
  logic signed [HUE_W-1:0] hue;

  assign f_sat = (factor > ONE_F) ? ONE_F : factor;
  assign f_s   = signed'(HUE_W'(f_sat));

  always_comb begin
    unique case (mode)
      RAMP_RETURN:     hue = TWO_ONE_H - (f_s <<< 1);
      RAMP_RISE_TWICE: hue = ONE_H + (f_s <<< 1);
      RAMP_RISE:       hue = ONE_H + f_s;
      RAMP_FALL:       hue = ONE_H - f_s;
      default:         hue = ONE_H - (f_s <<< 1);   // fall twice and unused codes
    endcase
  end

  assign frac.red   = hue_channel(hue + ONE_H);
  assign frac.green = hue_channel(hue);
  assign frac.blue  = hue_channel(hue - ONE_H);

endmodule

`default_nettype wire

// ===== hdl/hrcm_scale.sv =====
`default_nettype none

// Fractions -> 8-bit channels, single or 0.7/0.3 blend, truncating.
module hrcm_scale (
  input  wire logic            action,
  input  wire hrcm_pkg::frac_t frac_first,
  input  wire hrcm_pkg::frac_t frac_second,
  output hrcm_pkg::color_t     color
);
  import hrcm_pkg::*;

  localparam int SUM_W  = CHAN_W + 4;   // 7a + 3b <= 10*ONE
  localparam int PROD_W = SUM_W + 6;
  localparam int SGL_W  = CHAN_W + COLOR_W;
  // 255 / (10 * 2^F) == 51 / 2^(F+1)
  localparam logic [PROD_W-1:0] BLEND_NUM = PROD_W'(51);

  function automatic logic [COLOR_W-1:0] scale_single(logic [CHAN_W-1:0] c);
    logic [SGL_W-1:0] p;
    p = {c, {COLOR_W{1'b0}}} - SGL_W'(c);      // c * 255
    return p[FRACTION_BITS+COLOR_W-1:FRACTION_BITS];
  endfunction

  function automatic logic [COLOR_W-1:0] scale_blend(logic [CHAN_W-1:0] a,
                                                     logic [CHAN_W-1:0] b);
    logic [SUM_W-1:0]  s;
    logic [PROD_W-1:0] p;
    s = (SUM_W'(a) << 3) - SUM_W'(a) + (SUM_W'(b) << 1) + SUM_W'(b);
    p = PROD_W'(s) * BLEND_NUM;
    return p[FRACTION_BITS+COLOR_W:FRACTION_BITS+1];
  endfunction

  always_comb begin
    if (action == ACT_BLEND) begin
      color.red   = scale_blend(frac_first.red,   frac_second.red);
      color.green = scale_blend(frac_first.green, frac_second.green);
      color.blue  = scale_blend(frac_first.blue,  frac_second.blue);
    end else begin
      color.red   = scale_single(frac_first.red);
      color.green = scale_single(frac_first.green);
      color.blue  = scale_single(frac_first.blue);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hrcm_checker.sv =====
`default_nettype none

`include "hue_ramp_color_mapper_macros.svh"

// Port-level checks on the color mapper.
module hrcm_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_stall,
  input wire logic             color_valid,
  input wire logic             color_stall,
  input wire hrcm_pkg::color_t color
);
  import hrcm_pkg::*;

  // a stalled output word holds
  `HRCM_ASSERT_NEXT(a_color_hold, color_valid && color_stall, color_valid && $stable(color), "stalled color word changed")

  // input backpressure only comes from a stalled, occupied output
  `HRCM_ASSERT_SAME(a_stall_cause, item_stall, color_valid && color_stall, "input stalled without output backpressure")

  // reset empties the pipeline and releases the input
  `HRCM_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !color_valid && !item_stall, "pipeline not empty after reset")

endmodule

bind hue_ramp_color_mapper hrcm_checker u_hrcm_checker (.*);

`default_nettype wire
